// File: sv/ppmd_pkg.sv
// shared types and constants for the ppm p6 stream decoder
package ppmd_pkg;

  localparam int DIM_W   = 15;
  localparam int COUNT_W = 2 * DIM_W;
  localparam int TDATA_W = 72;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [DIM_W-1:0] ACC_MAX    = 15'h7FFF;
  localparam logic [DIM_W-1:0] MAXVAL_REQ = 15'd255;
  localparam logic [7:0]       ARGB_ALPHA = 8'hFF;

  typedef enum logic [2:0] {
    PH_MAGIC_P = 3'd0,
    PH_MAGIC_6 = 3'd1,
    PH_WIDTH   = 3'd2,
    PH_HEIGHT  = 3'd3,
    PH_MAXVAL  = 3'd4,
    PH_PIXELS  = 3'd5,
    PH_IDLE    = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_MAGIC  = 3'd0,
    ERR_NUMBER = 3'd1,
    ERR_SIZE   = 3'd2,
    ERR_MAXVAL = 3'd3,
    ERR_TRUNC  = 3'd4
  } err_e;

  typedef struct packed {
    kind_e             kind;
    logic [31:0]       pixel_argb;
    logic [DIM_W-1:0]  image_width;
    logic [DIM_W-1:0]  image_height;
    err_e              error_code;
    logic              final_pixel;
  } result_t;

endpackage

// File: sv/ppm_p6_stream_decoder.sv
// top level of the ppm p6 stream decoder
// usage:
//   s_axis carries the file one byte per transfer in tdata[7:0]; tlast marks the
//   final byte of a file. m_axis carries zero or one result per input byte:
//   tuser gives the kind (pixel, header complete, error), tlast flags the final
//   pixel of the image, and tdata holds the pixel word, the image size and the
//   error code.
//   a byte's result goes into the output register when the output is free, else
//   into the skid register. one byte is taken every cycle while tready is high;
//   the parse step and width times height product both settle between the state
//   registers and the output register, so a byte never waits on an earlier one.
//   results sit in a two-entry buffer (output register and skid register).
//   when m_axis stalls, the block keeps taking bytes until one result is held
//   in each entry; s_axis tready then drops until the receiver takes one.
//   errors are reported once; later bytes are dropped until a tlast byte. any
//   tlast byte returns the parser to waiting for the magic, ready for the next
//   file. bytes after the final pixel are dropped.
//   reset empties the buffer and puts the parser in the waiting-for-magic state;
//   tready is high from the first cycle after reset.
module ppm_p6_stream_decoder import ppmd_pkg::*; #(
  parameter int MAX_DIM = 16384
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,   // data_byte
  input  logic               s_axis_tlast_i,   // last_byte
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // pixel_argb[31:0], image_width[46:32], image_height[61:47], error_code[64:62]
  output logic [TDATA_W-1:0] m_axis_tdata_o,
  output logic [1:0]         m_axis_tuser_o,   // kind
  output logic               m_axis_tlast_o    // final_pixel
);

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  ppmd_parse #(
    .MAX_DIM(MAX_DIM)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .data_i     (s_axis_tdata_i),
    .last_i     (s_axis_tlast_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  ppmd_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept && res_valid),
    .push_data_i(res),
    .ready_o    (s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o (out)
  );

  assign m_axis_tdata_o = {7'd0, out.error_code, out.image_height, out.image_width,
                           out.pixel_argb};
  assign m_axis_tuser_o = out.kind;
  assign m_axis_tlast_o = out.final_pixel;

endmodule

// File: sv/ppmd_parse.sv
// header parser and pixel packer, one byte per transfer
module ppmd_parse import ppmd_pkg::*; #(
  parameter int MAX_DIM = 16384
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_i,
  input  logic       last_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  localparam logic [DIM_W-1:0] MaxDimW = DIM_W'(MAX_DIM);

  phase_e               phase_q, phase_d;
  logic                 in_comment_q, in_comment_d;
  logic [DIM_W-1:0]     accum_q, accum_d;
  logic                 saw_digit_q, saw_digit_d;
  logic [DIM_W-1:0]     width_q, width_d;
  logic [DIM_W-1:0]     height_q, height_d;
  logic [COUNT_W-1:0]   pixels_left_q, pixels_left_d;
  logic [15:0]          partial_q, partial_d;
  logic [1:0]           chan_q, chan_d;

  logic                 is_blank, is_digit, is_hash;
  logic [DIM_W+3:0]     acc_next;
  logic                 dim_ok;
  logic [COUNT_W-1:0]   pixel_count;

  assign is_blank = (data_i == CH_SPACE) || (data_i == CH_TAB) ||
                    (data_i == CH_CR) || (data_i == CH_LF);
  assign is_digit = (data_i >= CH_ZERO) && (data_i <= CH_NINE);
  assign is_hash  = (data_i == CH_HASH);
  assign acc_next = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0} +
                    {15'd0, data_i[3:0]};
  assign dim_ok   = (accum_q != '0) && (accum_q <= MaxDimW);
  assign pixel_count = COUNT_W'(width_q) * COUNT_W'(height_q);

  always_comb begin
    logic fail_en;
    err_e fail_code;
    logic [COUNT_W-1:0] left_dec;

    fail_en   = 1'b0;
    fail_code = ERR_MAGIC;
    left_dec  = (pixels_left_q != '0) ? pixels_left_q - COUNT_W'(1) : pixels_left_q;

    phase_d       = phase_q;
    in_comment_d  = in_comment_q;
    accum_d       = accum_q;
    saw_digit_d   = saw_digit_q;
    width_d       = width_q;
    height_d      = height_q;
    pixels_left_d = pixels_left_q;
    partial_d     = partial_q;
    chan_d        = chan_q;

    res_valid_o = 1'b0;
    res_o       = '0;

    unique case (phase_q)
      PH_MAGIC_P: begin
        if (data_i == CH_P) begin
          phase_d = PH_MAGIC_6;
        end else begin
          fail_en   = 1'b1;
          fail_code = ERR_MAGIC;
        end
      end
      PH_MAGIC_6: begin
        if (data_i == CH_SIX) begin
          phase_d      = PH_WIDTH;
          accum_d      = '0;
          saw_digit_d  = 1'b0;
          in_comment_d = 1'b0;
        end else begin
          fail_en   = 1'b1;
          fail_code = ERR_MAGIC;
        end
      end
      PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
        if (!saw_digit_q) begin
          // waiting for the first digit: blanks and comments
          if (in_comment_q) begin
            if (data_i == CH_LF) in_comment_d = 1'b0;
          end else if (is_hash) begin
            in_comment_d = 1'b1;
          end else if (is_digit) begin
            accum_d     = DIM_W'(data_i[3:0]);
            saw_digit_d = 1'b1;
          end else if (!is_blank) begin
            fail_en   = 1'b1;
            fail_code = ERR_NUMBER;
          end
        end else if (is_digit) begin
          accum_d = (acc_next > {4'd0, ACC_MAX}) ? ACC_MAX : acc_next[DIM_W-1:0];
        end else begin
          accum_d      = '0;
          saw_digit_d  = 1'b0;
          in_comment_d = 1'b0;
          if (phase_q == PH_MAXVAL) begin
            // terminator is the single separator byte
            if (accum_q != MAXVAL_REQ) begin
              fail_en   = 1'b1;
              fail_code = ERR_MAXVAL;
            end else begin
              pixels_left_d = pixel_count;
              chan_d        = '0;
              partial_d     = '0;
              phase_d       = PH_PIXELS;
              res_valid_o        = 1'b1;
              res_o.kind         = KIND_HEADER;
              res_o.image_width  = width_q;
              res_o.image_height = height_q;
            end
          end else if (!dim_ok) begin
            fail_en   = 1'b1;
            fail_code = ERR_SIZE;
          end else begin
            if (phase_q == PH_WIDTH) begin
              width_d = accum_q;
              phase_d = PH_HEIGHT;
            end else begin
              height_d = accum_q;
              phase_d  = PH_MAXVAL;
            end
            // terminator starts the next number
            if (is_hash) begin
              in_comment_d = 1'b1;
            end else if (!is_blank) begin
              fail_en   = 1'b1;
              fail_code = ERR_NUMBER;
            end
          end
        end
      end
      PH_PIXELS: begin
        unique case (chan_q)
          2'd0: begin
            partial_d = {data_i, 8'h00};
            chan_d    = 2'd1;
          end
          2'd1: begin
            partial_d = {partial_q[15:8], data_i};
            chan_d    = 2'd2;
          end
          default: begin
            partial_d     = '0;
            chan_d        = '0;
            pixels_left_d = left_dec;
            if (left_dec == '0) phase_d = PH_IDLE;
            res_valid_o       = 1'b1;
            res_o.kind        = KIND_PIXEL;
            res_o.pixel_argb  = {ARGB_ALPHA, partial_q, data_i};
            res_o.final_pixel = (left_dec == '0);
          end
        endcase
      end
      default: begin
      end
    endcase

    if (fail_en) begin
      phase_d          = PH_IDLE;
      res_valid_o      = 1'b1;
      res_o            = '0;
      res_o.kind       = KIND_ERROR;
      res_o.error_code = fail_code;
    end

    if (last_i) begin
      if (phase_q != PH_IDLE && phase_d != PH_IDLE) begin
        res_valid_o      = 1'b1;
        res_o            = '0;
        res_o.kind       = KIND_ERROR;
        res_o.error_code = ERR_TRUNC;
      end
      // end of file re-arms the parser
      phase_d       = PH_MAGIC_P;
      in_comment_d  = 1'b0;
      accum_d       = '0;
      saw_digit_d   = 1'b0;
      width_d       = '0;
      height_d      = '0;
      pixels_left_d = '0;
      partial_d     = '0;
      chan_d        = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_MAGIC_P;
      in_comment_q  <= 1'b0;
      accum_q       <= '0;
      saw_digit_q   <= 1'b0;
      width_q       <= '0;
      height_q      <= '0;
      pixels_left_q <= '0;
      partial_q     <= '0;
      chan_q        <= '0;
    end else if (accept_i) begin
      phase_q       <= phase_d;
      in_comment_q  <= in_comment_d;
      accum_q       <= accum_d;
      saw_digit_q   <= saw_digit_d;
      width_q       <= width_d;
      height_q      <= height_d;
      pixels_left_q <= pixels_left_d;
      partial_q     <= partial_d;
      chan_q        <= chan_d;
    end
  end

  a_last_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_i |=> phase_q == PH_MAGIC_P && chan_q == 2'd0)
    else $error("parser not re-armed after last byte");

  a_pixel_in_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && res_valid_o && res_o.kind == KIND_PIXEL |-> phase_q == PH_PIXELS)
    else $error("pixel result outside pixel phase");

  a_header_enters_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && res_valid_o && res_o.kind == KIND_HEADER |=>
      phase_q == PH_PIXELS && pixels_left_q != '0)
    else $error("header result without pixel phase");

endmodule

// File: sv/ppmd_outq.sv
// two-entry output buffer: output register plus skid register
module ppmd_outq import ppmd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    out_free;

  assign ready_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = push_data_i;
        out_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = push_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_valid_q)
    else $error("push into full output buffer");

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry without output entry");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && out_valid_q && !out_ready_i |=> skid_valid_q && skid_q == $past(push_data_i))
    else $error("stalled result not kept in skid register");

endmodule
